// ----- design/pid_controller_clamped_macros.svh -----
// ----------------------------------------------------------------------------
// pid_controller_clamped_macros
// Assertion shorthands shared by the PID controller RTL.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_MACROS_SVH
`define PID_CONTROLLER_CLAMPED_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define PCC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define PCC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pcc_pkg.sv -----
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared widths, register map and config struct of the clamped PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // field widths
  localparam int VAL_W   = 32;
  localparam int DT_W    = 31;
  localparam int ERR_W   = 33;
  localparam int DIFF_W  = 34;
  localparam int INTEG_W = 48;

  // stream payloads
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 120;

  // shared multiplier: signed A (digit-serial) times signed B
  localparam int MUL_A_W    = 48;
  localparam int MUL_B_W    = 33;
  localparam int DIG_W      = 16;
  localparam int MUL_DIGITS = MUL_A_W / DIG_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  // accumulator for the three gain terms
  localparam int SUM_W = PROD_W + 2;

  localparam logic signed [INTEG_W-1:0] LIM48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [INTEG_W-1:0] LIM48_MIN = 48'sh8000_0000_0000;

  // APB register map
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;
  localparam logic [IDX_W-1:0] REG_GAIN_P    = 3'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_I    = 3'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_D    = 3'd2;
  localparam logic [IDX_W-1:0] REG_OUT_MAX   = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUT_MIN   = 3'd4;
  localparam logic [IDX_W-1:0] REG_STEP_TIME = 3'd5;

  typedef struct packed {
    logic signed [VAL_W-1:0] gain_p;
    logic signed [VAL_W-1:0] gain_i;
    logic signed [VAL_W-1:0] gain_d;
    logic signed [VAL_W-1:0] out_max;
    logic signed [VAL_W-1:0] out_min;
    logic        [DT_W-1:0]  step_time;
  } pcc_cfg_t;

endpackage

`default_nettype wire

// ----- design/pcc_cfg.sv -----
// ----------------------------------------------------------------------------
// pcc_cfg
// APB register file holding gains, output limits and the sample period.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output pcc_pkg::pcc_cfg_t           cfg
);
  import pcc_pkg::*;

  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p    <= '0;
      cfg.gain_i    <= '0;
      cfg.gain_d    <= '0;
      cfg.out_max   <= 32'sh7FFF_FFFF;
      cfg.out_min   <= 32'sh8000_0000;
      cfg.step_time <= DT_W'(65536);
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN_P:    cfg.gain_p    <= pwdata;
        REG_GAIN_I:    cfg.gain_i    <= pwdata;
        REG_GAIN_D:    cfg.gain_d    <= pwdata;
        REG_OUT_MAX:   cfg.out_max   <= pwdata;
        REG_OUT_MIN:   cfg.out_min   <= pwdata;
        REG_STEP_TIME: cfg.step_time <= pwdata[DT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:    prdata = cfg.gain_p;
      REG_GAIN_I:    prdata = cfg.gain_i;
      REG_GAIN_D:    prdata = cfg.gain_d;
      REG_OUT_MAX:   prdata = cfg.out_max;
      REG_OUT_MIN:   prdata = cfg.out_min;
      REG_STEP_TIME: prdata = {1'b0, cfg.step_time};
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/pcc_mul.sv -----
// ----------------------------------------------------------------------------
// pcc_mul
// Shared signed multiplier, one 16-bit digit of A per cycle, MSB digit first.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [pcc_pkg::MUL_A_W-1:0]  op_a,
  input  logic signed [pcc_pkg::MUL_B_W-1:0]  op_b,
  output logic signed [pcc_pkg::PROD_W-1:0]   prod,
  output logic                                done
);
  import pcc_pkg::*;

  localparam int CNT_W = $clog2(MUL_DIGITS);

  logic [MUL_A_W-1:0]              a_sh;
  logic signed [MUL_B_W-1:0]       b_reg;
  logic                            busy;
  logic [CNT_W-1:0]                cnt;
  logic                            first;
  logic signed [DIG_W:0]           dig;
  logic signed [MUL_B_W+DIG_W:0]   pp;

  // top digit carries the sign, lower digits are unsigned
  assign first = (cnt == '0);
  assign dig   = first ? {a_sh[MUL_A_W-1], a_sh[MUL_A_W-1 -: DIG_W]}
                       : {1'b0, a_sh[MUL_A_W-1 -: DIG_W]};
  assign pp    = b_reg * dig;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh  <= op_a;
      b_reg <= op_b;
    end else if (busy) begin
      prod <= first ? PROD_W'(pp) : (prod <<< DIG_W) + PROD_W'(pp);
      a_sh <= a_sh << DIG_W;
    end
  end

endmodule

`default_nettype wire

// ----- design/pcc_div.sv -----
// ----------------------------------------------------------------------------
// pcc_div
// Derivative divider: (diff << FRAC_BITS) / dt, radix-4 restoring, truncated
// toward zero and saturated to 48 signed bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_div #(
  parameter int FRAC_BITS = pcc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [pcc_pkg::DIFF_W-1:0]   diff,
  input  logic [pcc_pkg::DT_W-1:0]            period,
  output logic signed [pcc_pkg::INTEG_W-1:0]  deriv,
  output logic                                valid
);
  import pcc_pkg::*;

  // magnitude of diff is below 2^33, so the dividend needs 33+FRAC_BITS bits
  localparam int STEPS = (FRAC_BITS + DIFF_W) / 2;
  localparam int DW    = 2 * STEPS;
  localparam int CW    = $clog2(STEPS);
  localparam int EW    = (DW > INTEG_W) ? DW : INTEG_W;
  localparam logic [EW-1:0] POS_LIM = EW'(48'h7FFF_FFFF_FFFF);
  localparam logic [EW-1:0] NEG_LIM = EW'(48'h8000_0000_0000);

  logic                      busy;
  logic                      fin;
  logic [CW-1:0]             cnt;
  logic                      neg;
  logic [DT_W-1:0]           dt_reg;
  logic [DT_W-1:0]           rem;
  logic [DW-1:0]             dvd;
  logic [DIFF_W-1:0]         mag_in;
  logic [DT_W:0]             t1;
  logic [DT_W:0]             t2;
  logic                      ge1;
  logic                      ge2;
  logic [DT_W-1:0]           r1;
  logic [DT_W-1:0]           r2;
  logic [EW-1:0]             q_ext;
  logic signed [INTEG_W-1:0] deriv_next;

  assign mag_in = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;

  // two quotient bits per cycle
  assign t1  = {rem, dvd[DW-1]};
  assign ge1 = (t1 >= {1'b0, dt_reg});
  assign r1  = ge1 ? DT_W'(t1 - {1'b0, dt_reg}) : t1[DT_W-1:0];
  assign t2  = {r1, dvd[DW-2]};
  assign ge2 = (t2 >= {1'b0, dt_reg});
  assign r2  = ge2 ? DT_W'(t2 - {1'b0, dt_reg}) : t2[DT_W-1:0];

  assign q_ext = EW'(dvd);

  always_comb begin
    if (!neg) begin
      deriv_next = (q_ext > POS_LIM) ? LIM48_MAX : $signed(q_ext[INTEG_W-1:0]);
    end else begin
      deriv_next = (q_ext > NEG_LIM) ? LIM48_MIN : -$signed(q_ext[INTEG_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      fin   <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      fin   <= 1'b0;
      valid <= 1'b0;
      cnt   <= CW'(STEPS - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end else if (fin) begin
      fin   <= 1'b0;
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg    <= diff[DIFF_W-1];
      dt_reg <= period;
      rem    <= '0;
      dvd    <= {{(DW - DIFF_W){1'b0}}, mag_in} << FRAC_BITS;
    end else if (busy) begin
      rem <= r2;
      dvd <= {dvd[DW-3:0], ge1, ge2};
    end else if (fin) begin
      deriv <= deriv_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/pid_controller_clamped.sv -----
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Clamped discrete PID controller in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_tdata carries one sample (setpoint, measured); each transfer gives one
//   result on m_tdata (drive, integral_now, error_now). Gains, limits and
//   the sample period dt are set over the APB port while the block is idle.
//   The radix-4 derivative divider sets the latency from input transfer to
//   m_tvalid; the shared digit-serial multiplier runs err*dt and the P and
//   I terms meanwhile and the D term after the divider finishes.
//   Flow: one item at a time; s_tready is high only when idle, so no new
//   transfer is taken until the previous item has reached the output register.
//   A finished result waits in the output register, and the next input is
//   taken while it waits. If the receiver still stalls when the following
//   result is ready, the block holds that result internally until the
//   output register frees.
//   Reset clears the integral and the previous error, restores the register
//   defaults (unity dt, full-range limits, zero gains) and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_clamped #(
  parameter int FRAC_BITS = pcc_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // from bit 0 up: setpoint, measured
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [pcc_pkg::IN_TDATA_W-1:0]      s_tdata,
  // from bit 0 up: drive, integral_now, error_now, zero pad
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [pcc_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcc_pkg::ADDR_W-1:0]          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import pcc_pkg::*;

`include "pid_controller_clamped_macros.svh"

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_INC    = 4'd1;
  localparam logic [3:0] ST_INC_W  = 4'd2;
  localparam logic [3:0] ST_PROP   = 4'd3;
  localparam logic [3:0] ST_PROP_W = 4'd4;
  localparam logic [3:0] ST_INTG   = 4'd5;
  localparam logic [3:0] ST_INTG_W = 4'd6;
  localparam logic [3:0] ST_DER    = 4'd7;
  localparam logic [3:0] ST_DER_W  = 4'd8;
  localparam logic [3:0] ST_CLAMP  = 4'd9;

  pcc_cfg_t                  cfg;
  logic [3:0]                state;
  logic [3:0]                state_next;
  logic signed [ERR_W-1:0]   err;
  logic signed [ERR_W-1:0]   last_error;
  logic signed [INTEG_W-1:0] integral_acc;
  logic signed [SUM_W-1:0]   sum;

  logic                      accept;
  logic                      out_free;
  logic [DT_W-1:0]           dt_eff;
  logic signed [DIFF_W-1:0]  diff;

  logic                      mul_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_prod;
  logic                      mul_done;

  logic                      div_start;
  logic signed [INTEG_W-1:0] deriv;
  logic                      div_valid;

  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [64:0]        integ_sum;
  logic signed [INTEG_W-1:0] integ_next;
  logic signed [SUM_W-1:0]   sum_sh;
  logic signed [VAL_W-1:0]   drive;

  pcc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .prod  (mul_prod),
    .done  (mul_done)
  );

  pcc_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .diff   (diff),
    .period (dt_eff),
    .deriv  (deriv),
    .valid  (div_valid)
  );

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign dt_eff   = (cfg.step_time == '0) ? DT_W'(1) : cfg.step_time;
  assign diff     = DIFF_W'(err) - DIFF_W'(last_error);

  assign div_start = (state == ST_INC);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = MUL_A_W'(err);
    mul_b     = '0;
    unique case (state)
      ST_INC: begin
        mul_start = 1'b1;
        mul_b     = {2'b00, dt_eff};
      end
      ST_PROP: begin
        mul_start = 1'b1;
        mul_b     = MUL_B_W'(cfg.gain_p);
      end
      ST_INTG: begin
        mul_start = 1'b1;
        mul_a     = integral_acc;
        mul_b     = MUL_B_W'(cfg.gain_i);
      end
      ST_DER: begin
        mul_start = div_valid;
        mul_a     = deriv;
        mul_b     = MUL_B_W'(cfg.gain_d);
      end
      default: ;
    endcase
  end

  // integral update: floor(err*dt / 2^F) added with 48-bit saturation
  assign prod_sh   = mul_prod >>> FRAC_BITS;
  assign integ_sum = 65'(integral_acc) + $signed(prod_sh[64:0]);
  always_comb begin
    if (integ_sum > 65'(LIM48_MAX)) begin
      integ_next = LIM48_MAX;
    end else if (integ_sum < 65'(LIM48_MIN)) begin
      integ_next = LIM48_MIN;
    end else begin
      integ_next = integ_sum[INTEG_W-1:0];
    end
  end

  // upper limit is tested first: when the limits cross, a sum above out_max gives out_max, any other sum out_min
  assign sum_sh = sum >>> FRAC_BITS;
  always_comb begin
    if (sum_sh > SUM_W'(cfg.out_max)) begin
      drive = cfg.out_max;
    end else if (sum_sh < SUM_W'(cfg.out_min)) begin
      drive = cfg.out_min;
    end else begin
      drive = sum_sh[VAL_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_INC;
      ST_INC:    state_next = ST_INC_W;
      ST_INC_W:  if (mul_done) state_next = ST_PROP;
      ST_PROP:   state_next = ST_PROP_W;
      ST_PROP_W: if (mul_done) state_next = ST_INTG;
      ST_INTG:   state_next = ST_INTG_W;
      ST_INTG_W: if (mul_done) state_next = ST_DER;
      ST_DER:    if (div_valid) state_next = ST_DER_W;
      ST_DER_W:  if (mul_done) state_next = ST_CLAMP;
      ST_CLAMP:  if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      integral_acc <= '0;
      last_error   <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_INC_W && mul_done) begin
        integral_acc <= integ_next;
      end
      if (state == ST_CLAMP && out_free) begin
        last_error <= err;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err <= ERR_W'($signed(s_tdata[VAL_W-1:0])) -
             ERR_W'($signed(s_tdata[2*VAL_W-1:VAL_W]));
    end
    if (mul_done) begin
      if (state == ST_PROP_W) begin
        sum <= SUM_W'(mul_prod);
      end else if (state == ST_INTG_W || state == ST_DER_W) begin
        sum <= sum + SUM_W'(mul_prod);
      end
    end
    if (state == ST_CLAMP && out_free) begin
      m_tdata <= {{(OUT_TDATA_W - VAL_W - INTEG_W - ERR_W){1'b0}},
                  err, integral_acc, drive};
    end
  end

  `PCC_ASSERT_NXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while busy")
  `PCC_ASSERT_IMP(a_mul_idle_when_idle, state == ST_IDLE, !mul_done, "multiplier finished while idle")
  `PCC_ASSERT_NXT(a_der_waits_divider, state == ST_DER && !div_valid, state == ST_DER, "D term started before the divider finished")

endmodule

`default_nettype wire
